>>> design/skpad_pkg.sv
package skpad_pkg;

    // Default build of the keypad.
    localparam int DEF_KEY_COUNT         = 7;
    localparam int DEF_VIRTUAL_KEY_INDEX = 6;
    localparam int DEF_TIME_WIDTH        = 48;

    // Fixed field widths.
    localparam int BUTTON_W    = 6;
    localparam int KEY_NUM_W   = 3;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int OUT_TDATA_W = 8;
    localparam int ARROW_W     = 4;

    // Register values after reset.
    localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 32'd4800000;
    localparam logic [CFG_W-1:0] RST_FIRST_REPEAT = 32'd96000000;
    localparam logic [CFG_W-1:0] RST_SECOND_REPEAT = 32'd48000000;
    localparam logic [CFG_W-1:0] RST_STEADY_REPEAT = 32'd9600000;
    localparam logic [CFG_W-1:0] RST_IDLE_TIMEOUT = 32'd1920000000;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE      = 3'd0,
        CFG_FIRST_REPEAT  = 3'd1,
        CFG_SECOND_REPEAT = 3'd2,
        CFG_STEADY_REPEAT = 3'd3,
        CFG_IDLE_TIMEOUT  = 3'd4
    } t_cfg_idx;

    // Debounced level of one key.
    typedef enum logic [1:0] {
        LV_UP     = 2'd0,
        LV_DOWN   = 2'd1,
        LV_IGNORE = 2'd2
    } t_level;

    // Last thing that happened to one key.
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_PRESS  = 3'd3,
        EV_REP1   = 3'd4,
        EV_REP2   = 3'd5,
        EV_IGNORE = 3'd6
    } t_key_ev;

    // Event code reported on the output.
    typedef enum logic [1:0] {
        OUT_NONE   = 2'd0,
        OUT_PRESS  = 2'd1,
        OUT_REPEAT = 2'd2
    } t_out_ev;

    // Control part of one key's stored state.
    typedef struct packed {
        t_level  level;
        t_key_ev last_ev;
    } t_key_ctl;

    localparam t_key_ctl KEY_CTL_RST = '{level: LV_UP, last_ev: EV_NONE};

    // Timing registers as seen by the update logic.
    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] first_repeat;
        logic [CFG_W-1:0] second_repeat;
        logic [CFG_W-1:0] steady_repeat;
        logic [CFG_W-1:0] idle_timeout;
    } t_cfg_regs;

endpackage

>>> design/scanned_keypad_debounce_autorepeat.sv
// Scanned keypad with debounce and auto-repeat.
// Each input beat on the s-side is one scan step: tdata carries the active-low
// button bits and the current time. Each step scans the next key of a
// round-robin pointer and gives exactly one output beat on the m-side with the
// key number, the event (none, press on release, hold repeat), a backlight
// request and the busy flag.
// The user writes timing registers via the i_cfg_* port only while the block
// idles; the block does not enforce it. Beats pass the read stage, then the
// output register, one step every cycle unless the receiver stalls. Key state
// memory is read at the input beat, written back as the read stage moves on;
// a key returns KEY_COUNT steps later, so reads and writes never share an entry.
// The output beat sits in a register; while the receiver stalls, one more step
// waits in the read stage and then s_tready drops until the output is taken.
// Reset clears the pointer, the busy state (busy set) and the valid bits of the
// key memory at once, so all keys read as up with no event; no beat is lost
// or repeated across a stall.
module scanned_keypad_debounce_autorepeat import skpad_pkg::*; #(
    parameter int KEY_COUNT         = DEF_KEY_COUNT,
    parameter int VIRTUAL_KEY_INDEX = DEF_VIRTUAL_KEY_INDEX,
    parameter int TIME_WIDTH        = DEF_TIME_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                   i_cfg_idx,
    input  logic [CFG_W-1:0]                       i_cfg_data,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // button_levels, now_ticks, zero fill
    input  logic [((BUTTON_W+TIME_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // key_number, key_event, backlight_request, keyboard_busy, zero fill
    output logic [OUT_TDATA_W-1:0]                 m_tdata
);

    localparam int PW = $clog2(KEY_COUNT);

    t_cfg_regs             r_cfg;
    logic [PW-1:0]         r_scan_ptr;
    logic [PW-1:0]         n_scan_ptr;
    logic                  r_s1_valid;
    logic [PW-1:0]         r_s1_key;
    logic [BUTTON_W-1:0]   r_s1_levels;
    logic [TIME_WIDTH-1:0] r_s1_now;
    logic                  r_busy;
    logic                  n_busy;
    logic [TIME_WIDTH-1:0] r_last_press;
    logic [TIME_WIDTH-1:0] n_last_press;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                  in_beat;
    logic                  s1_go;
    t_key_ctl              rd_ctl;
    logic [TIME_WIDTH-1:0] rd_stamp;
    t_key_ctl              wr_ctl;
    logic [TIME_WIDTH-1:0] wr_stamp;
    t_out_ev               key_ev;
    logic                  light;
    logic [TIME_WIDTH-1:0] idle_elapsed;

    // Handshake: the read stage moves on when the output register frees up.
    assign s1_go    = r_s1_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_s1_valid || s1_go;
    assign in_beat  = s_tvalid && s_tready;

    // Timing registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{debounce: RST_DEBOUNCE, first_repeat: RST_FIRST_REPEAT,
                       second_repeat: RST_SECOND_REPEAT,
                       steady_repeat: RST_STEADY_REPEAT,
                       idle_timeout: RST_IDLE_TIMEOUT};
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE:      r_cfg.debounce      <= i_cfg_data;
                CFG_FIRST_REPEAT:  r_cfg.first_repeat  <= i_cfg_data;
                CFG_SECOND_REPEAT: r_cfg.second_repeat <= i_cfg_data;
                CFG_STEADY_REPEAT: r_cfg.steady_repeat <= i_cfg_data;
                CFG_IDLE_TIMEOUT:  r_cfg.idle_timeout  <= i_cfg_data;
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    // Round-robin pointer: advanced before the scan.
    assign n_scan_ptr = (r_scan_ptr == PW'(KEY_COUNT - 1)) ? '0 : r_scan_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_ptr <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_scan_ptr <= n_scan_ptr;
            end
            if (in_beat) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Read-stage payload.
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_key    <= n_scan_ptr;
            r_s1_levels <= s_tdata[BUTTON_W-1:0];
            r_s1_now    <= s_tdata[BUTTON_W +: TIME_WIDTH];
        end
    end

    skpad_key_mem #(
        .KEY_COUNT  (KEY_COUNT),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_beat),
        .i_rd_addr  (n_scan_ptr),
        .o_rd_ctl   (rd_ctl),
        .o_rd_stamp (rd_stamp),
        .i_wr_en    (s1_go),
        .i_wr_addr  (r_s1_key),
        .i_wr_ctl   (wr_ctl),
        .i_wr_stamp (wr_stamp)
    );

    skpad_key_update #(
        .KEY_COUNT         (KEY_COUNT),
        .VIRTUAL_KEY_INDEX (VIRTUAL_KEY_INDEX),
        .TIME_WIDTH        (TIME_WIDTH)
    ) u_update (
        .i_key    (r_s1_key),
        .i_levels (r_s1_levels),
        .i_now    (r_s1_now),
        .i_cfg    (r_cfg),
        .i_ctl    (rd_ctl),
        .i_stamp  (rd_stamp),
        .o_ctl    (wr_ctl),
        .o_stamp  (wr_stamp),
        .o_event  (key_ev),
        .o_light  (light)
    );

    // Busy timeout: a real press refreshes it, then the expiry check runs.
    assign n_last_press = light ? r_s1_now : r_last_press;
    assign idle_elapsed = r_s1_now - n_last_press;
    assign n_busy = (r_busy || light) &&
                    !(idle_elapsed > TIME_WIDTH'(r_cfg.idle_timeout));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b1;
            r_last_press <= '0;
        end else if (s1_go) begin
            r_busy       <= n_busy;
            r_last_press <= n_last_press;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out_data <= {1'b0, n_busy, light, key_ev, KEY_NUM_W'(r_s1_key)};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

>>> design/skpad_key_mem.sv
module skpad_key_mem import skpad_pkg::*; #(
    parameter int KEY_COUNT  = DEF_KEY_COUNT,
    parameter int TIME_WIDTH = DEF_TIME_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(KEY_COUNT)-1:0] i_rd_addr,
    output t_key_ctl                     o_rd_ctl,
    output logic [TIME_WIDTH-1:0]        o_rd_stamp,
    input  logic                         i_wr_en,
    input  logic [$clog2(KEY_COUNT)-1:0] i_wr_addr,
    input  t_key_ctl                     i_wr_ctl,
    input  logic [TIME_WIDTH-1:0]        i_wr_stamp
);

    // Per-key state: one write port, one registered read port.
    t_key_ctl                r_ctl_mem [KEY_COUNT];
    logic [TIME_WIDTH-1:0]   r_stamp_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0]    r_valid;
    t_key_ctl                r_rd_ctl;
    logic [TIME_WIDTH-1:0]   r_rd_stamp;
    logic                    r_rd_valid;

    // An entry that was never written reads as its reset value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_ctl_mem[i_wr_addr]   <= i_wr_ctl;
            r_stamp_mem[i_wr_addr] <= i_wr_stamp;
        end
    end

    // Read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_ctl   <= r_ctl_mem[i_rd_addr];
            r_rd_stamp <= r_stamp_mem[i_rd_addr];
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_ctl   = r_rd_valid ? r_rd_ctl : KEY_CTL_RST;
    assign o_rd_stamp = r_rd_valid ? r_rd_stamp : '0;

endmodule

>>> design/skpad_key_update.sv
module skpad_key_update import skpad_pkg::*; #(
    parameter int KEY_COUNT         = DEF_KEY_COUNT,
    parameter int VIRTUAL_KEY_INDEX = DEF_VIRTUAL_KEY_INDEX,
    parameter int TIME_WIDTH        = DEF_TIME_WIDTH
) (
    input  logic [$clog2(KEY_COUNT)-1:0] i_key,
    input  logic [BUTTON_W-1:0]          i_levels,
    input  logic [TIME_WIDTH-1:0]        i_now,
    input  t_cfg_regs                    i_cfg,
    input  t_key_ctl                     i_ctl,
    input  logic [TIME_WIDTH-1:0]        i_stamp,
    output t_key_ctl                     o_ctl,
    output logic [TIME_WIDTH-1:0]        o_stamp,
    output t_out_ev                      o_event,
    output logic                         o_light
);

    localparam int PW    = $clog2(KEY_COUNT);
    localparam int SLOTS = 1 << PW;

    logic [SLOTS-1:0]      lv_ext;
    logic [ARROW_W-1:0]    arrows;
    logic                  is_virtual;
    logic                  raw_down;
    t_level                cur;
    logic [CFG_W-1:0]      interval;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  over;

    // Keys past the button field read as pressed (their bits are zero).
    assign lv_ext     = SLOTS'(i_levels);
    assign is_virtual = (i_key == PW'(VIRTUAL_KEY_INDEX));
    assign raw_down   = !lv_ext[i_key];

    // The scanned key counts as released for the arrow test.
    always_comb begin
        for (int i = 0; i < ARROW_W; i++) begin
            arrows[i] = i_levels[i] | (i_key == PW'(i));
        end
    end

    // Classify the scanned key.
    always_comb begin
        if (is_virtual) begin
            cur = (i_levels[ARROW_W-1:0] == '0) ? LV_DOWN : LV_UP;
        end else if (!raw_down) begin
            cur = LV_UP;
        end else if (arrows != '1) begin
            cur = LV_IGNORE;
        end else begin
            cur = LV_DOWN;
        end
    end

    assign o_light = !is_virtual && raw_down;

    // Only one interval matters for any given case, so one compare serves all.
    always_comb begin
        priority if (cur == LV_UP) begin
            interval = i_cfg.debounce;
        end else if (i_ctl.last_ev == EV_REP1) begin
            interval = i_cfg.second_repeat;
        end else if (i_ctl.last_ev == EV_REP2) begin
            interval = i_cfg.steady_repeat;
        end else begin
            interval = i_cfg.first_repeat;
        end
    end

    assign elapsed = i_now - i_stamp;
    assign over    = elapsed > TIME_WIDTH'(interval);

    // Next state of the key and the event it gives.
    always_comb begin
        o_ctl   = i_ctl;
        o_stamp = i_stamp;
        o_event = OUT_NONE;
        unique case (cur)
            LV_UP: begin
                if (i_ctl.level == LV_DOWN) begin
                    if (i_ctl.last_ev == EV_DOWN) begin
                        // Released too early: wait for the debounce time.
                        if (over) begin
                            o_ctl   = '{level: LV_UP, last_ev: EV_PRESS};
                            o_stamp = i_now;
                            o_event = OUT_PRESS;
                        end
                    end else begin
                        o_ctl   = '{level: LV_UP, last_ev: EV_UP};
                        o_stamp = i_now;
                    end
                end else begin
                    o_ctl = '{level: LV_UP, last_ev: EV_UP};
                end
            end
            LV_DOWN: begin
                if (i_ctl.level == LV_UP) begin
                    o_ctl   = '{level: LV_DOWN, last_ev: EV_DOWN};
                    o_stamp = i_now;
                end else if (i_ctl.level == LV_DOWN && over) begin
                    if (i_ctl.last_ev == EV_DOWN) begin
                        o_ctl.last_ev = EV_REP1;
                        o_stamp       = i_now;
                        o_event       = OUT_REPEAT;
                    end else if (i_ctl.last_ev == EV_REP1) begin
                        o_ctl.last_ev = EV_REP2;
                        o_stamp       = i_now;
                        o_event       = OUT_REPEAT;
                    end else if (i_ctl.last_ev == EV_REP2) begin
                        o_stamp = i_now;
                        o_event = OUT_REPEAT;
                    end
                end
            end
            LV_IGNORE: begin
                o_ctl = '{level: LV_IGNORE, last_ev: EV_IGNORE};
            end
            default: begin
                o_ctl = i_ctl;
            end
        endcase
    end

endmodule

>>> design/skpad_checker.sv
module skpad_checker import skpad_pkg::*; #(
    parameter int KEY_COUNT         = DEF_KEY_COUNT,
    parameter int VIRTUAL_KEY_INDEX = DEF_VIRTUAL_KEY_INDEX
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // A stalled output beat holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // The event code never takes its unused value.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[4:3] != 2'd3)
        else $error("undefined key event code");

    // A press seen this step leaves the keyboard busy.
    a_light_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[5] |-> m_tdata[6])
        else $error("backlight request without busy flag");

    // The virtual key is never a real press.
    a_virtual_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && (KEY_COUNT <= 8) && (m_tdata[2:0] == 3'(VIRTUAL_KEY_INDEX))
        |-> !m_tdata[5])
        else $error("backlight request from the virtual key");

    // Nothing is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind scanned_keypad_debounce_autorepeat skpad_checker #(
    .KEY_COUNT         (KEY_COUNT),
    .VIRTUAL_KEY_INDEX (VIRTUAL_KEY_INDEX)
) u_skpad_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
